// File: rtl/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// shared types and constants of the battery charge estimator
// ----------------------------------------------------------------------------
package bce_pkg;

    // field widths
    localparam int SMP_W  = 11;   // pin sample, mV
    localparam int MVF_W  = 14;   // full battery voltage (median times five)
    localparam int MV_W   = 13;   // battery voltage as delivered
    localparam int PCT_W  = 7;    // charge percent
    localparam int LAST_W = 8;    // stored previous percent

    // discharge curve
    localparam int CURVE_POINTS = 21;
    localparam int IDX_W  = $clog2(CURVE_POINTS);
    localparam int SPAN_W = 9;    // widest curve segment is 340 mV

    // divider operands
    localparam int NUM_W = SPAN_W + PCT_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
        13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3950,
        13'd3910, 13'd3870, 13'd3850, 13'd3840, 13'd3820, 13'd3800, 13'd3790,
        13'd3770, 13'd3750, 13'd3730, 13'd3710, 13'd3690, 13'd3610, 13'd3270
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
        7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
        7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
    };

    localparam logic [MV_W-1:0]   MV_SAT       = 13'd8191;
    localparam logic [LAST_W-1:0] NO_READING   = 8'd255;
    localparam logic [LAST_W-1:0] PCT_LIMIT    = 8'd100;
    localparam logic [PCT_W-1:0]  MAX_DROP_RST = 7'd10;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  numer;
        logic [SPAN_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quot;
    } div_rsp_t;

endpackage

// File: rtl/bce_div.sv
// ----------------------------------------------------------------------------
// bce_div
// restoring shift-subtract divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bce_div
    import bce_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SPAN_W-1:0] rem_reg, rem_next;
    logic [SPAN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;

    logic [SPAN_W:0]   trial;
    logic [SPAN_W:0]   diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.denom;
            quo_next  = req.numer;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops
            rem_next = ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

// File: rtl/battery_charge_estimator.sv
// ----------------------------------------------------------------------------
// battery_charge_estimator
// lipo state of charge from three divided-pin samples, with downward slew limit
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload (lowest bit first)
//  s_        in   s_tvalid/s_tready    sample_first, sample_second, sample_third
//  m_        out  m_tvalid/m_tready    battery_mv, charge_pct
//  cfg_      in   cfg_valid/cfg_ready  max_drop
//
//  an item at or beyond a curve end goes from the median step straight to the
//  slew limit; otherwise the one-point-per-cycle search finds curve segment
//  k = 1..20, then the product and the 16-step divider give the percent
//  s_tready is high only in idle; a finished item waits in the output register
//  so the next item is taken while m_tready is low
//  reset (aresetn low, synchronous) clears max_drop to 10 and the previous
//  reading to "none"; cfg_ready is always high
// ----------------------------------------------------------------------------
module battery_charge_estimator
    import bce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // sample_first[10:0], sample_second[21:11],
                                   // sample_third[32:22], zero pad [39:33]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // battery_mv[12:0], charge_pct[19:13],
                                   // zero pad [23:20]
    // max_drop register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // max_drop[6:0]
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MED,
        ST_SEARCH,
        ST_MULT,
        ST_DSTART,
        ST_DWAIT,
        ST_SLEW,
        ST_DONE
    } state_t;

    state_t state_reg;

    // item working registers
    logic [SMP_W-1:0]  smp_a_reg, smp_b_reg, smp_c_reg;
    logic [MVF_W-1:0]  mv_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SPAN_W-1:0] diff_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [PCT_W-1:0]  dp_reg;
    logic [PCT_W-1:0]  plo_reg;
    logic [NUM_W-1:0]  prod_reg;
    logic [PCT_W-1:0]  pct_raw_reg;
    logic [PCT_W-1:0]  pct_reg;

    // persistent state
    logic [PCT_W-1:0]  max_drop_reg;
    logic [LAST_W-1:0] last_reg;

    // output register
    logic              m_valid_reg;
    logic [MV_W-1:0]   out_mv_reg;
    logic [PCT_W-1:0]  out_pct_reg;

    // divider instance
    div_req_t div_req;
    div_rsp_t div_rsp;

    bce_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign div_req.start = (state_reg == ST_DSTART);
    assign div_req.numer = prod_reg;
    assign div_req.denom = span_reg;

    // median of three
    logic [SMP_W-1:0] med;
    always_comb begin
        if ((smp_a_reg <= smp_b_reg && smp_b_reg <= smp_c_reg) ||
            (smp_c_reg <= smp_b_reg && smp_b_reg <= smp_a_reg)) begin
            med = smp_b_reg;
        end else if ((smp_b_reg <= smp_a_reg && smp_a_reg <= smp_c_reg) ||
                     (smp_c_reg <= smp_a_reg && smp_a_reg <= smp_b_reg)) begin
            med = smp_a_reg;
        end else begin
            med = smp_c_reg;
        end
    end

    // median times five as shift and add
    logic [MVF_W-1:0] mv_full;
    assign mv_full = {1'b0, med, 2'b00} + MVF_W'(med);

    // current curve segment: point idx is the low end, idx-1 the high end
    logic [IDX_W-1:0] idx_hi;
    logic [MVF_W-1:0] seg_lo_mv;
    logic [MV_W-1:0]  seg_span;
    logic [MVF_W-1:0] seg_diff;
    assign idx_hi    = idx_reg - 1'b1;
    assign seg_lo_mv = MVF_W'(CURVE_MV[idx_reg]);
    assign seg_span  = CURVE_MV[idx_hi] - CURVE_MV[idx_reg];
    assign seg_diff  = mv_reg - seg_lo_mv;

    // downward slew limit
    logic [LAST_W-1:0] pct_ext;
    logic [LAST_W-1:0] fall;
    logic [LAST_W-1:0] limited;
    logic              limit_hit;
    assign pct_ext   = {1'b0, pct_raw_reg};
    assign fall      = last_reg - pct_ext;
    assign limited   = last_reg - {1'b0, max_drop_reg};
    assign limit_hit = (last_reg <= PCT_LIMIT) && (pct_ext < last_reg) &&
                       (fall > {1'b0, max_drop_reg});

    // finished item moves into the output register once that is free
    logic out_load;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            max_drop_reg <= MAX_DROP_RST;
            last_reg     <= NO_READING;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_drop_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        smp_a_reg <= s_tdata[10:0];
                        smp_b_reg <= s_tdata[21:11];
                        smp_c_reg <= s_tdata[32:22];
                        state_reg <= ST_MED;
                    end
                end
                ST_MED: begin
                    mv_reg  <= mv_full;
                    idx_reg <= IDX_W'(1);
                    // at or beyond either end of the curve the percent is fixed
                    if (mv_full >= MVF_W'(CURVE_MV[0])) begin
                        pct_raw_reg <= CURVE_PCT[0];
                        state_reg   <= ST_SLEW;
                    end else if (mv_full <= MVF_W'(CURVE_MV[CURVE_POINTS-1])) begin
                        pct_raw_reg <= CURVE_PCT[CURVE_POINTS-1];
                        state_reg   <= ST_SLEW;
                    end else begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    // one curve point per cycle, top down
                    if (mv_reg >= seg_lo_mv) begin
                        diff_reg  <= seg_diff[SPAN_W-1:0];
                        span_reg  <= seg_span[SPAN_W-1:0];
                        dp_reg    <= CURVE_PCT[idx_hi] - CURVE_PCT[idx_reg];
                        plo_reg   <= CURVE_PCT[idx_reg];
                        state_reg <= ST_MULT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_MULT: begin
                    prod_reg <= NUM_W'(diff_reg) * NUM_W'(dp_reg);
                    // flat segment gives the low point directly
                    if (span_reg == '0) begin
                        pct_raw_reg <= plo_reg;
                        state_reg   <= ST_SLEW;
                    end else begin
                        state_reg <= ST_DSTART;
                    end
                end
                ST_DSTART: begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT: begin
                    // quotient stays below the segment's percent step
                    if (div_rsp.done) begin
                        pct_raw_reg <= plo_reg + div_rsp.quot[PCT_W-1:0];
                        state_reg   <= ST_SLEW;
                    end
                end
                ST_SLEW: begin
                    if (limit_hit) begin
                        pct_reg  <= limited[PCT_W-1:0];
                        last_reg <= limited;
                    end else begin
                        pct_reg  <= pct_raw_reg;
                        last_reg <= pct_ext;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // hand over once the output register is free
                    if (out_load) begin
                        out_mv_reg  <= (mv_reg > MVF_W'(MV_SAT)) ? MV_SAT
                                                                  : mv_reg[MV_W-1:0];
                        out_pct_reg <= pct_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0000, out_pct_reg, out_mv_reg};
    assign cfg_ready = 1'b1;

endmodule

// File: rtl/bce_checker.sv
// ----------------------------------------------------------------------------
// bce_checker
// port-level checks of the battery charge estimator
// ----------------------------------------------------------------------------
module bce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [6:0]  cfg_data
);

    // no item is shown right after reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // the block works on one item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while busy");

    // percent never exceeds full charge
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:13] <= 7'd100))
        else $error("charge percent out of range");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind battery_charge_estimator bce_checker u_bce_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);
